>>> rtl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder
// Byte class masks and the result burst handed from decode to emit.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 3;   // up to four results per byte

    // byte classes: (byte & MASK) == CODE
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] CONT_DATA  = 8'h3F;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD2_DATA = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD3_DATA = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] LEAD4_DATA = 8'h07;
    localparam logic [7:0] ASCII_LIM  = 8'h80;

    // results caused by one byte: all but the final one are errors
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CP_W-1:0]  code_point;   // final result, zero when invalid
        logic             invalid;      // final result
    } t_burst;

endpackage

>>> rtl/u8sd_decode.sv
// ----------------------------------------------------------------------------
// u8sd_decode: sequence state and per-byte decode
// Updates the open-sequence state on each accepted byte and describes the
// burst of results that byte causes.
// ----------------------------------------------------------------------------
module u8sd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output u8sd_pkg::t_burst  o_burst
);

    logic [u8sd_pkg::CP_W-1:0] r_pv, n_pv;
    logic [1:0]                r_exp, n_exp;
    logic [1:0]                r_rcv, n_rcv;

    logic                      is_cont;
    logic                      idle_path;
    logic [1:0]                rcv_inc;
    logic [u8sd_pkg::CP_W-1:0] acc;
    logic [2:0]                errs;
    logic                      res;
    logic [u8sd_pkg::CP_W-1:0] res_cp;
    logic                      res_inv;
    logic                      done;

    // decode the byte against the open sequence
    always_comb begin
        is_cont   = (i_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE;
        idle_path = (r_exp == 2'd0) || !is_cont;
        rcv_inc   = r_rcv + 2'd1;
        acc       = {r_pv[u8sd_pkg::CP_W-7:0], i_byte[5:0]};
        n_pv      = r_pv;
        n_exp     = r_exp;
        n_rcv     = r_rcv;
        errs      = 3'd0;
        res       = 1'b0;
        res_cp    = '0;
        res_inv   = 1'b0;
        done      = 1'b0;

        if (r_exp != 2'd0 && is_cont) begin
            // continuation: shift in six bits, close when complete
            if (rcv_inc >= r_exp) begin
                done  = 1'b1;
                n_pv  = '0;
                n_exp = 2'd0;
                n_rcv = 2'd0;
            end else begin
                n_pv  = acc;
                n_rcv = rcv_inc;
            end
        end else if (r_exp != 2'd0) begin
            // broken sequence: one error for the lead, one per taken byte
            errs  = 3'd1 + {1'b0, (r_rcv > 2'd2) ? 2'd2 : r_rcv};
            n_pv  = '0;
            n_exp = 2'd0;
            n_rcv = 2'd0;
        end

        if (idle_path) begin
            if (i_byte == 8'd0) begin
                // end of text: nothing
            end else if (i_byte < u8sd_pkg::ASCII_LIM) begin
                res    = 1'b1;
                res_cp = {{(u8sd_pkg::CP_W-8){1'b0}}, i_byte};
            end else if ((i_byte & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
                n_pv  = {{(u8sd_pkg::CP_W-8){1'b0}}, i_byte & u8sd_pkg::LEAD2_DATA};
                n_exp = 2'd1;
                n_rcv = 2'd0;
            end else if ((i_byte & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
                n_pv  = {{(u8sd_pkg::CP_W-8){1'b0}}, i_byte & u8sd_pkg::LEAD3_DATA};
                n_exp = 2'd2;
                n_rcv = 2'd0;
            end else if ((i_byte & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
                n_pv  = {{(u8sd_pkg::CP_W-8){1'b0}}, i_byte & u8sd_pkg::LEAD4_DATA};
                n_exp = 2'd3;
                n_rcv = 2'd0;
            end else begin
                res     = 1'b1;
                res_inv = 1'b1;
            end
        end

        // describe the burst: final result first from the idle handling
        o_burst.count = errs + {2'b00, res} + {2'b00, done};
        if (res) begin
            o_burst.code_point = res_cp;
            o_burst.invalid    = res_inv;
        end else if (done) begin
            o_burst.code_point = acc;
            o_burst.invalid    = 1'b0;
        end else begin
            o_burst.code_point = '0;
            o_burst.invalid    = 1'b1;
        end
    end

    // advance sequence state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= '0;
            r_exp <= 2'd0;
            r_rcv <= 2'd0;
        end else if (i_accept) begin
            r_pv  <= n_pv;
            r_exp <= n_exp;
            r_rcv <= n_rcv;
        end
    end

    // an open sequence never holds all its continuation bytes
    a_rcv_below_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != 2'd0) |-> (r_rcv < r_exp))
        else $error("received count reached expected count");

    // a closed sequence leaves no partial bits behind
    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp == 2'd0) |-> (r_rcv == 2'd0 && r_pv == '0))
        else $error("closed sequence holds stale state");

endmodule

>>> rtl/u8sd_emit.sv
// ----------------------------------------------------------------------------
// u8sd_emit: result register and error replay
// Holds one burst and hands its results out one per request, errors first.
// ----------------------------------------------------------------------------
module u8sd_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  u8sd_pkg::t_burst           i_burst,
    output logic                       o_load_ok,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [u8sd_pkg::CP_W-1:0]  o_code_point,
    output logic                       o_invalid,
    output logic                       o_last_of_run
);

    logic [u8sd_pkg::CNT_W-1:0] r_cnt;
    logic [u8sd_pkg::CP_W-1:0]  r_cp;
    logic                       r_inv;
    logic                       take;
    logic                       final_one;

    // drive the current result: earlier ones are bare errors
    always_comb begin
        final_one     = r_cnt == 3'd1;
        o_valid       = r_cnt != 3'd0;
        take          = o_valid && !i_stall;
        o_code_point  = final_one ? r_cp : '0;
        o_invalid     = !final_one || r_inv;
        o_last_of_run = final_one;
        o_load_ok     = (r_cnt == 3'd0) || (final_one && !i_stall);
    end

    // load a new burst or count down on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // hold the final result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cp  <= i_burst.code_point;
            r_inv <= i_burst.invalid;
        end
    end

    // one byte never causes more than four results
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("burst count above four");

    // an error result carries a zero code point
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_code_point == '0))
        else $error("error result with nonzero code point");

    // a taken non-final result steps the count down by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_cnt > 3'd1) |=> (r_cnt == $past(r_cnt) - 3'd1))
        else $error("replay count skipped");

endmodule

>>> rtl/utf8_stream_decoder.sv
// A byte's first result is offered in the cycle after the byte is accepted.
// One byte per cycle while each byte yields at most one result and the output is not stalled.
// A byte that yields k results (k up to 4) holds the input until its final result is taken,
// set by the single result register that replays the errors one per cycle while not stalled.
// Reset (synchronous, active low) closes any open sequence and drops pending results.
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// Takes one text byte per request and emits decoded code points and error
// results, with a flag on the last result caused by each byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic        o_invalid,
    output logic        o_last_of_run
);

    u8sd_pkg::t_burst burst;
    logic             load_ok;
    logic             accept;

    // accept a byte whenever the result register frees up this cycle
    assign o_in_stall = !load_ok;
    assign accept     = i_in_valid && load_ok;

    u8sd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_text_byte),
        .o_burst  (burst)
    );

    u8sd_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_burst       (burst),
        .o_load_ok     (load_ok),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_code_point  (o_code_point),
        .o_invalid     (o_invalid),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> tb/tb_utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder: self-checking bench for the UTF-8 stream decoder
// Feeds directed and random text bytes through a randomly idling driver,
// predicts every code point and error result in a local decoder model and
// checks each result field by field at a randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

    localparam int unsigned CP_W         = u8sd_pkg::CP_W;
    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid;
        logic            last_of_run;
    } t_decoded;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_stall;
    logic [7:0]      i_text_byte = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    logic [CP_W-1:0] o_code_point;
    logic            o_invalid;
    logic            o_last_of_run;

    // local decoder state
    logic [CP_W-1:0] seq_value = '0;
    logic [1:0]      seq_need  = '0;
    logic [1:0]      seq_got   = '0;

    logic [7:0]      text_queue[$];
    t_decoded        cp_due[$];
    t_decoded        byte_results[$];

    int unsigned     gap_left   = 0;
    int unsigned     stall_left = 0;
    bit              in_calm    = 1'b0;
    bit              out_calm   = 1'b0;
    int unsigned     n_bytes    = 0;
    int unsigned     n_results  = 0;
    int unsigned     n_errors   = 0;
    int unsigned     n_fail     = 0;
    int unsigned     n_cycles   = 0;

    utf8_stream_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_invalid     (o_invalid),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Append one result for the byte being decoded
    function automatic void add_result(logic [CP_W-1:0] cp, logic bad);
        t_decoded r;
        r.code_point  = bad ? '0 : cp;
        r.invalid     = bad;
        r.last_of_run = 1'b0;
        byte_results.push_back(r);
    endfunction

    // Handle a byte with no sequence open: end of text, ASCII, lead or error
    function automatic void decode_idle_byte(logic [7:0] b);
        if (b == 8'h00) begin
            seq_got = seq_got;
        end else if (b < u8sd_pkg::ASCII_LIM) begin
            add_result(CP_W'(b), 1'b0);
        end else if ((b & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_CODE) begin
            seq_value = CP_W'(b & u8sd_pkg::LEAD2_DATA);
            seq_need  = 2'd1;
            seq_got   = 2'd0;
        end else if ((b & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_CODE) begin
            seq_value = CP_W'(b & u8sd_pkg::LEAD3_DATA);
            seq_need  = 2'd2;
            seq_got   = 2'd0;
        end else if ((b & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_CODE) begin
            seq_value = CP_W'(b & u8sd_pkg::LEAD4_DATA);
            seq_need  = 2'd3;
            seq_got   = 2'd0;
        end else begin
            add_result('0, 1'b1);
        end
    endfunction

    // Predict all results of one accepted byte and queue them
    function automatic void predict_decode(logic [7:0] b);
        int unsigned n_replay;
        byte_results.delete();
        if (seq_need == 2'd0) begin
            decode_idle_byte(b);
        end else if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE) begin
            seq_value = CP_W'(seq_value << 6) | CP_W'(b & u8sd_pkg::CONT_DATA);
            seq_got   = seq_got + 2'd1;
            if (seq_got >= seq_need) begin
                add_result(seq_value, 1'b0);
                seq_value = '0;
                seq_need  = '0;
                seq_got   = '0;
            end
        end else begin
            // broken sequence: error for the lead, then one per taken continuation
            add_result('0, 1'b1);
            n_replay = (seq_got > 2'd2) ? 2 : seq_got;
            repeat (n_replay) add_result('0, 1'b1);
            seq_value = '0;
            seq_need  = '0;
            seq_got   = '0;
            decode_idle_byte(b);
        end
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        foreach (byte_results[i]) cp_due.push_back(byte_results[i]);
    endfunction

    // Queue a lead byte for a len-byte sequence and n_cont continuation bytes
    function automatic void push_sequence(int unsigned len, int unsigned n_cont);
        logic [7:0] lead;
        case (len)
            2: begin
                lead = u8sd_pkg::LEAD2_CODE | (8'($urandom) & u8sd_pkg::LEAD2_DATA);
            end
            3: begin
                lead = u8sd_pkg::LEAD3_CODE | (8'($urandom) & u8sd_pkg::LEAD3_DATA);
            end
            default: begin
                lead = u8sd_pkg::LEAD4_CODE | (8'($urandom) & u8sd_pkg::LEAD4_DATA);
            end
        endcase
        text_queue.push_back(lead);
        repeat (n_cont)
            text_queue.push_back(u8sd_pkg::CONT_CODE |
                                 (8'($urandom) & u8sd_pkg::CONT_DATA));
    endfunction

    // Mostly well-formed sequences, some broken ones, some raw noise
    task automatic add_random_item();
        int unsigned pick;
        int unsigned len;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            text_queue.push_back(8'($urandom_range(1, 127)));
        end else if (pick < 75) begin
            len = (pick < 45) ? 2 : (pick < 60) ? 3 : 4;
            push_sequence(len, len - 1);
        end else if (pick < 88) begin
            len = $urandom_range(2, 4);
            push_sequence(len, $urandom_range(0, len - 2));
            do b = 8'($urandom); while ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_CODE);
            if ($urandom_range(0, 3) == 0) b = 8'h00;
            text_queue.push_back(b);
        end else if (pick < 95) begin
            text_queue.push_back(8'($urandom));
        end else begin
            text_queue.push_back(8'h00);
        end
    endtask

    // Drive requests from the text queue with a random gap per byte
    always @(posedge i_clk) begin
        int unsigned gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            predict_decode(i_text_byte);
            n_bytes++;
            if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
            gap = in_calm ? 0 : $urandom_range(0, 15);
            if (text_queue.size() != 0 && gap == 0) begin
                i_text_byte <= text_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                gap_left   <= gap;
            end
        end else if (!i_in_valid) begin
            if (gap_left > 1) begin
                gap_left <= gap_left - 1;
            end else if (text_queue.size() != 0) begin
                i_in_valid  <= 1'b1;
                i_text_byte <= text_queue.pop_front();
                gap_left    <= 0;
            end
        end
    end

    // Accept results, compare against the oldest prediction, then stall at random
    always @(posedge i_clk) begin
        t_decoded    want;
        int unsigned wait_n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            n_results++;
            if (o_invalid) n_errors++;
            if (cp_due.size() == 0) begin
                $error("unexpected result: code_point=%h invalid=%b last_of_run=%b",
                       o_code_point, o_invalid, o_last_of_run);
                n_fail++;
            end else begin
                want = cp_due.pop_front();
                if (o_code_point !== want.code_point) begin
                    $error("code_point: expected %h, got %h", want.code_point, o_code_point);
                    n_fail++;
                end
                if (o_invalid !== want.invalid) begin
                    $error("invalid: expected %b, got %b", want.invalid, o_invalid);
                    n_fail++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, got %b", want.last_of_run,
                           o_last_of_run);
                    n_fail++;
                end
            end
            if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
            wait_n = out_calm ? 0 : $urandom_range(0, 15);
            stall_left  <= wait_n;
            i_out_stall <= (wait_n != 0);
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", n_cycles,
                     cp_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned base;
        // ASCII and end of text, invalid leads, each sequence length, the
        // largest code point, and broken sequences ending in error, ASCII,
        // a new lead and end of text
        text_queue = '{8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
                       8'hC2, 8'hA9,
                       8'hE2, 8'h82, 8'hAC,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hF0, 8'h90, 8'h80, 8'hFF,
                       8'hE2, 8'h82, 8'h41,
                       8'hC3, 8'hC3, 8'hA9,
                       8'hF0, 8'h80, 8'h00};
        base = text_queue.size();
        while (text_queue.size() - base < RANDOM_BYTES) add_random_item();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain stimulus and predictions, then watch for stray results
        while (text_queue.size() != 0 || i_in_valid || cp_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d text bytes and %0d checked results, %0d of them errors.",
                 n_bytes, n_results, n_errors);
        $display("Field mismatches or stray results: %0d", n_fail);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
